>>> design/mcct_pkg.sv
// ----------------------------------------------------------------------------
// mcct_pkg
// Shared types and codes for the multi-channel countdown timer unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mcct_pkg;

  localparam int CH_W    = 4;
  localparam int DELAY_W = 16;
  localparam int STEP_W  = 15;

  // request op codes
  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [CH_W-1:0]    channel;
    logic [DELAY_W-1:0] delay_ms;
    logic signed [15:0] elapsed_ms;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] fired_channel;
    logic            last_of_run;
  } out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               arm;
    logic               cancel;
    logic               tick;
    logic [CH_W-1:0]    channel;
    logic [DELAY_W-1:0] delay;
    logic [STEP_W-1:0]  step;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } scan_state_t;

endpackage

`default_nettype wire

>>> design/mcct_cell.sv
// ----------------------------------------------------------------------------
// mcct_cell
// One countdown channel: pending mark, count, expiry flag and scan token.
// ----------------------------------------------------------------------------
`default_nettype none

module mcct_cell #(
  parameter int IDX = 0
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  mcct_pkg::cell_cmd_t cmd,
  input  wire                 shift,
  input  wire                 tok_i,
  output logic                tok_o,
  output logic                hit_o
);
  import mcct_pkg::*;

  logic               armed_r, armed_nxt;
  logic               exp_r, exp_nxt;
  logic               tok_r, tok_nxt;
  logic [DELAY_W-1:0] rem_r, rem_nxt;
  logic               match;
  logic [DELAY_W-1:0] step_ext;

  assign match    = (int'(cmd.channel) == IDX);
  assign step_ext = DELAY_W'(cmd.step);
  assign tok_o    = tok_r;
  assign hit_o    = tok_r & exp_r;

  always_comb begin
    armed_nxt = armed_r;
    exp_nxt   = exp_r;
    rem_nxt   = rem_r;
    tok_nxt   = shift ? tok_i : tok_r;
    // flag is consumed as the token leaves
    if (shift && tok_r) begin
      exp_nxt = 1'b0;
    end
    if (cmd.arm && match && !armed_r) begin
      armed_nxt = 1'b1;
      rem_nxt   = cmd.delay;
    end
    if (cmd.cancel && match) begin
      armed_nxt = 1'b0;
    end
    if (cmd.tick && armed_r) begin
      if (rem_r <= step_ext) begin
        armed_nxt = 1'b0;
        exp_nxt   = 1'b1;
      end else begin
        rem_nxt = rem_r - step_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      exp_r   <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
      exp_r   <= exp_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

endmodule

`default_nettype wire

>>> design/multi_channel_countdown_timer_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_countdown_timer_unit
// Table of countdown channels with ordered expiry reporting.
// ----------------------------------------------------------------------------
// Arm and cancel requests are applied on acceptance. A tick request is
// applied to every channel at once on acceptance, then a token walks the
// row of channel cells one cell per cycle, pausing while a new find waits
// on a held report that a stalled result side cannot take. Expired channels are
// reported in ascending order; each report is held back one find so the
// final one of a tick can carry last_of_run. The input side is blocked
// (in_ready low) while a tick is being walked. Channels at or above 16 exist
// when CHANNELS > 16 but cannot be addressed by the 4-bit channel field.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_countdown_timer_unit #(
  parameter int CHANNELS = 16
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  mcct_pkg::in_t  in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output mcct_pkg::out_t out_data
);
  import mcct_pkg::*;

  localparam int IDX_W = $clog2(CHANNELS);

  scan_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [CH_W-1:0]  hold_ch_r, hold_ch_nxt;
  logic             out_v_r, out_v_nxt;
  out_t             out_data_r, out_data_nxt;

  logic             in_acc, tick_acc;
  logic             out_free, hit_any, adv, push, push_last, hold_load, hold_clr;
  logic             scan_end;
  logic [STEP_W-1:0] step;
  cell_cmd_t        cmd;
  logic [CHANNELS-1:0] tok, hit;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign tick_acc  = in_acc && (in_data.op == OP_TICK);
  assign out_free  = !out_v_r || out_ready;
  assign hit_any   = |hit;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // elapsed time of zero or below counts as one millisecond
  always_comb begin
    if (in_data.elapsed_ms <= 16'sd0) begin
      step = STEP_W'(1);
    end else begin
      step = in_data.elapsed_ms[STEP_W-1:0];
    end
  end

  always_comb begin
    cmd.arm     = in_acc && (in_data.op == OP_ARM);
    cmd.cancel  = in_acc && (in_data.op == OP_CANCEL);
    cmd.tick    = tick_acc;
    cmd.channel = in_data.channel;
    cmd.delay   = in_data.delay_ms;
    cmd.step    = step;
  end

  // row of channel cells, token enters at cell 0 when a tick is taken
  genvar gi;
  generate
    for (gi = 0; gi < CHANNELS; gi++) begin : g_cell
      logic tok_in;
      if (gi == 0) begin : g_head
        assign tok_in = tick_acc;
      end else begin : g_body
        assign tok_in = tok[gi-1];
      end
      mcct_cell #(.IDX(gi)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .shift (adv | tick_acc),
        .tok_i (tok_in),
        .tok_o (tok[gi]),
        .hit_o (hit[gi])
      );
    end
  endgenerate

  // scan outputs
  always_comb begin
    adv       = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    hold_load = 1'b0;
    hold_clr  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_SCAN: begin
        if (!(hit_any && hold_v_r && !out_free)) begin
          adv = 1'b1;
          if (hit_any) begin
            push      = hold_v_r;
            hold_load = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (hold_v_r && out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          hold_clr  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign scan_end = adv && (idx_r == IDX_W'(CHANNELS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (tick_acc) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_end) state_nxt = ST_FLUSH;
      ST_FLUSH: if (!hold_v_r || out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (tick_acc) begin
      idx_nxt = '0;
    end else if (adv) begin
      idx_nxt = idx_r + IDX_W'(1);
    end

    hold_v_nxt  = hold_v_r;
    hold_ch_nxt = hold_ch_r;
    if (hold_load) begin
      hold_v_nxt  = 1'b1;
      hold_ch_nxt = CH_W'(idx_r);
    end else if (hold_clr) begin
      hold_v_nxt = 1'b0;
    end

    out_v_nxt    = out_v_r;
    out_data_nxt = out_data_r;
    if (push) begin
      out_v_nxt                  = 1'b1;
      out_data_nxt.fired_channel = hold_ch_r;
      out_data_nxt.last_of_run   = push_last;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_ch_r  <= hold_ch_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

>>> design/mcct_checker.sv
// ----------------------------------------------------------------------------
// mcct_checker
// Port-level checks on the countdown timer unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcct_checker (
  input wire            clk,
  input wire            rst_n,
  input wire            in_valid,
  input wire            in_ready,
  input mcct_pkg::in_t  in_data,
  input wire            out_valid,
  input wire            out_ready,
  input mcct_pkg::out_t out_data
);
  import mcct_pkg::*;

  // a result waiting on the far side is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result withdrawn or changed while stalled");

  // a tick blocks further requests while the row is walked
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_TICK |=> !in_ready)
    else $error("request taken during tick scan");

  // arm and cancel never produce a report
  a_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op != OP_TICK |=> !$rose(out_valid))
    else $error("report after a non-tick request");

  // nothing is reported straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multi_channel_countdown_timer_unit mcct_checker u_mcct_checker (.*);

`default_nettype wire

>>> dv/tb_multi_channel_countdown_timer_unit.sv
// ----------------------------------------------------------------------------
// tb_multi_channel_countdown_timer_unit
// Self-checking bench for the countdown timer table: arm, cancel and tick
// requests are pushed in under random back-pressure. A behavioural copy of
// the channel table predicts every expiry report, and each report is checked
// in order against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multi_channel_countdown_timer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mcct_pkg::*;

  localparam int CHANNELS       = 16;
  // a tick walks every cell once, plus some slack for the report pipeline
  localparam int DRAIN_CYCLES   = CHANNELS + 8;
  // cycles with no request or report accepted before the run is abandoned;
  // far above the longest sender gap or receiver stall plus a full walk
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 250;
  localparam logic [1:0] OP_SPARE = 2'd3;  // unused code, must be ignored

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data  = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  multi_channel_countdown_timer_unit #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioural channel table
  // --------------------------------------------------------------------------
  logic        chan_armed [CHANNELS];
  logic [16:0] chan_left  [CHANNELS];
  out_t        fires_due[$];   // expiry reports not yet seen, oldest first
  int          mismatches = 0;

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      chan_armed[i] = 1'b0;
      chan_left[i]  = '0;
    end
  end

  // Update the table for one accepted request and queue the reports it causes.
  function automatic void apply_request(in_t req);
    logic signed [15:0] elapsed;
    logic [16:0]        step;
    int                 first_fire;
    out_t               rpt;
    first_fire = fires_due.size();
    case (req.op)
      OP_ARM: begin
        // re-arming a pending channel must not reload its count
        if (!chan_armed[req.channel]) begin
          chan_armed[req.channel] = 1'b1;
          chan_left[req.channel]  = {1'b0, req.delay_ms};
        end
      end
      OP_CANCEL: begin
        chan_armed[req.channel] = 1'b0;
      end
      OP_TICK: begin
        // zero or negative elapsed time still counts as one millisecond
        elapsed = req.elapsed_ms;
        step    = (elapsed < 16'sd1) ? 17'd1 : {1'b0, elapsed};
        for (int i = 0; i < CHANNELS; i++) begin
          if (chan_armed[i]) begin
            if (chan_left[i] <= step) begin
              chan_armed[i]     = 1'b0;
              chan_left[i]      = '0;
              rpt.fired_channel = CH_W'(i);
              rpt.last_of_run   = 1'b0;
              fires_due.push_back(rpt);
            end else begin
              chan_left[i] = chan_left[i] - step;
            end
          end
        end
        // flag the final report of this tick
        if (fires_due.size() > first_fire)
          fires_due[fires_due.size()-1].last_of_run = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_fire(out_t got);
    out_t exp_rpt;
    if (fires_due.size() == 0) begin
      $error("unexpected report: fired_channel %0d last_of_run %0b",
             got.fired_channel, got.last_of_run);
      mismatches++;
      return;
    end
    exp_rpt = fires_due.pop_front();
    if (got.fired_channel !== exp_rpt.fired_channel) begin
      $error("fired_channel: expected %0d, actual %0d",
             exp_rpt.fired_channel, got.fired_channel);
      mismatches++;
    end
    if (got.last_of_run !== exp_rpt.last_of_run) begin
      $error("last_of_run: expected %0b, actual %0b",
             exp_rpt.last_of_run, got.last_of_run);
      mismatches++;
    end
  endfunction

  // Both handshakes sampled at the same edge; prediction goes first so a
  // report can never overtake the request that caused it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        apply_request(in_data);
      if (out_valid && out_ready)
        check_fire(out_data);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: abandons the run if traffic stops moving
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Gaps and back-pressure
  // --------------------------------------------------------------------------
  logic gaps_on   = 1'b0;  // sender leaves holes between requests
  logic stalls_on = 1'b0;  // receiver drops out_ready at random
  int   stall_left = 0;

  // mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  always @(posedge clk) begin
    if (!stalls_on) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 35) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one request, hold it until taken, then maybe leave a gap.
  // in_valid is only lowered when a gap follows, so back-to-back requests
  // never see two assignments to it in one step.
  task automatic send_request(input logic [1:0] op, input logic [CH_W-1:0] ch,
                              input logic [DELAY_W-1:0] delay,
                              input logic [15:0] elapsed);
    in_t         req;
    int unsigned gap;
    req.op         = op;
    req.channel    = ch;
    req.delay_ms   = delay;
    req.elapsed_ms = elapsed;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [CH_W-1:0] any_ch();
    return CH_W'($urandom_range(0, CHANNELS-1));
  endfunction

  function automatic logic [15:0] any_word();
    return 16'($urandom());
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty table: a tick reports nothing, cancelling an idle channel and the
  // spare op code change nothing.
  task automatic test_idle_table();
    send_request(OP_TICK, any_ch(), any_word(), 16'sd5);
    send_request(OP_CANCEL, 4'd3, any_word(), any_word());
    send_request(OP_SPARE, any_ch(), any_word(), any_word());
  endtask

  // Zero and full-scale delays, arm of a pending channel, cancel of a pending
  // channel, and ticks at zero, most negative and most positive elapsed time.
  // Channel 15 ends on an exact zero count.
  task automatic test_arm_and_expiry();
    send_request(OP_ARM, 4'd0, 16'd0, any_word());
    send_request(OP_ARM, 4'd15, 16'hFFFF, any_word());
    send_request(OP_ARM, 4'd0, 16'd500, any_word());   // ignored, still pending
    send_request(OP_ARM, 4'd7, 16'd10, any_word());
    send_request(OP_CANCEL, 4'd7, any_word(), any_word());
    send_request(OP_TICK, any_ch(), any_word(), 16'sd0);        // ch0 fires
    send_request(OP_TICK, any_ch(), any_word(), 16'sh8000);     // counts as 1
    send_request(OP_TICK, any_ch(), any_word(), 16'sh7FFF);
    send_request(OP_TICK, any_ch(), any_word(), 16'sh7FFE);     // ch15 at zero
  endtask

  // Every channel pending at once: one tick gives a full run of reports.
  task automatic test_full_sweep();
    for (int i = 0; i < CHANNELS; i++)
      send_request(OP_ARM, CH_W'(i), 16'($urandom_range(0, 2000)), any_word());
    send_request(OP_TICK, any_ch(), any_word(), 16'sh7FFF);
  endtask

  // Mostly arms with short delays and ticks with modest elapsed times so
  // channels keep expiring; the rest are cancels, odd tick values, wide
  // delays and the spare code. Idling switches on and off in blocks.
  task automatic test_random_traffic();
    int unsigned roll;
    logic [15:0] delay;
    logic [15:0] elapsed;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        gaps_on   = 1'($urandom_range(0, 1));
        stalls_on = 1'($urandom_range(0, 1));
      end
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        delay = ($urandom_range(0, 4) == 0) ? any_word()
                                            : 16'($urandom_range(0, 300));
        send_request(OP_ARM, any_ch(), delay, any_word());
      end else if (roll < 50) begin
        send_request(OP_CANCEL, any_ch(), any_word(), any_word());
      end else if (roll < 88) begin
        roll = $urandom_range(0, 99);
        if (roll < 70)
          elapsed = 16'($urandom_range(1, 120));
        else if (roll < 85)
          elapsed = -16'($urandom_range(0, 32768));
        else
          elapsed = any_word();
        send_request(OP_TICK, any_ch(), any_word(), elapsed);
      end else begin
        send_request(OP_SPARE, any_ch(), any_word(), any_word());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_table();
    test_arm_and_expiry();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_full_sweep();
    test_random_traffic();

    // drain: every predicted report must arrive, then a walk's worth of
    // quiet to catch any stray ones
    in_valid <= 1'b0;
    while (fires_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
